// ----- design/bounded_deque_defines.svh -----
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Concurrent assertion shorthands used by the bounded deque top-level file.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded deque package
// Request and status codes and the response flag struct.
// ----------------------------------------------------------------------------
package bdq_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic    pop_ok;
        t_status status;
    } t_resp;

endpackage

// ----- design/bdq_ring.sv -----
// ----------------------------------------------------------------------------
// Bounded deque ring control
// Front pointer and entry count; turns a transaction into memory accesses.
// ----------------------------------------------------------------------------
module bdq_ring #(
    parameter int DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  bdq_pkg::t_req                i_req_type,
    output logic                         o_wr_en,
    output logic [$clog2(DEPTH)-1:0]     o_wr_addr,
    output logic                         o_rd_en,
    output logic [$clog2(DEPTH)-1:0]     o_rd_addr,
    output bdq_pkg::t_resp               o_resp,
    output logic [$clog2(DEPTH+1)-1:0]   o_fill
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_sum_m1;
    logic [AW-1:0] w_back;
    logic [AW-1:0] w_last;
    logic [AW-1:0] w_front_dec;
    logic [AW-1:0] w_front_inc;
    logic          w_full;
    logic          w_empty;

    always_comb begin
        w_sum    = SW'(r_front) + SW'(r_count);
        w_sum_m1 = w_sum - 1'b1;
        w_back   = (w_sum >= SW'(DEPTH)) ? AW'(w_sum - SW'(DEPTH)) : w_sum[AW-1:0];
        w_last   = (w_sum_m1 >= SW'(DEPTH)) ? AW'(w_sum_m1 - SW'(DEPTH))
                                             : w_sum_m1[AW-1:0];
        w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
        w_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        w_full  = (r_count == CW'(DEPTH));
        w_empty = (r_count == '0);
    end

    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        o_wr_en       = 1'b0;
        o_wr_addr     = w_back;
        o_rd_en       = 1'b0;
        o_rd_addr     = r_front;
        o_resp.pop_ok = 1'b0;
        o_resp.status = ST_OK;
        case (i_req_type)
            REQ_PUSH_FRONT: begin
                o_wr_addr = w_front_dec;
                if (w_full) begin
                    o_resp.status = ST_OVERFLOW;
                end else begin
                    o_wr_en = i_accept;
                    n_front = w_front_dec;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (w_full) begin
                    o_resp.status = ST_OVERFLOW;
                end else begin
                    o_wr_en = i_accept;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (w_empty) begin
                    o_resp.status = ST_UNDERFLOW;
                end else begin
                    o_rd_en       = i_accept;
                    o_resp.pop_ok = 1'b1;
                    n_front       = w_front_inc;
                    n_count       = r_count - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                o_rd_addr = w_last;
                if (w_empty) begin
                    o_resp.status = ST_UNDERFLOW;
                end else begin
                    o_rd_en       = i_accept;
                    o_resp.pop_ok = 1'b1;
                    n_count       = r_count - 1'b1;
                end
            end
            default: begin
                o_resp.status = ST_OK;
            end
        endcase
        o_fill = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

endmodule

// ----- design/bounded_deque.sv -----
// ----------------------------------------------------------------------------
// Bounded deque
// Fixed-capacity double-ended queue of signed 32-bit words in a ring memory.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Ports
//  -------   ------------------   ---------------------------------------------
//  request   start & !busy        i_req_type, i_push_value
//  result    o_strobe (1 cycle)   o_pop_value, o_status, o_fill_level
//
//  Every transaction produces exactly one result, in the cycle after acceptance.
//  A new transaction may be accepted in every cycle: the memory write of a push
//  and the registered read of a pop both complete at the accepting clock edge,
//  so busy is never raised and the sustained rate is one transaction per cycle.
//  Reset is synchronous and active low; it empties the queue. Stored words have
//  no reset: a pop only ever reads an entry that an earlier push wrote.
//  The receiver cannot stall; each result is present for exactly one cycle.
//
module bounded_deque #(
    parameter int DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bdq_pkg::t_req                i_req_type,
    input  logic signed [31:0]           i_push_value,
    output logic                         o_strobe,
    output logic signed [31:0]           o_pop_value,
    output bdq_pkg::t_status             o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_fill_level
);
    import bdq_pkg::*;

    `include "bounded_deque_defines.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // The ring memory: one write port and one registered read port.
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    logic          w_accept;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_resp         w_resp;
    logic [CW-1:0] w_fill;

    logic          r_strobe;
    logic          r_pop_ok;
    t_status       r_status;
    logic [CW-1:0] r_fill;

    // Every transaction completes at the edge that accepts it, so the block
    // never needs to hold off the requester.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    bdq_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req_type),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .o_resp     (w_resp),
        .o_fill     (w_fill)
    );

    // A push and a pop never occur in the same transaction, so the write and
    // the read never touch the memory at the same edge. A pop that follows a
    // push reads at a later edge and sees the stored word.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_push_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Result register: status and fill level travel alongside the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_ok <= w_resp.pop_ok;
            r_status <= w_resp.status;
            r_fill   <= w_fill;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_pop_value  = r_pop_ok ? r_rd_data : '0;
    assign o_status     = r_status;
    assign o_fill_level = r_fill;

    // Every accepted transaction yields a result in the following cycle.
    `BDQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, o_strobe, "result missing")
    // The fill level never exceeds the capacity.
    `BDQ_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, o_strobe, o_fill_level <= CW'(DEPTH), "fill above capacity")
    // A rejected push is only reported when the queue is full.
    `BDQ_ASSERT_NOW(a_overflow_full, i_clk, i_rst_n, o_strobe && o_status == ST_OVERFLOW, o_fill_level == CW'(DEPTH), "overflow while not full")
    // An underflow is only reported when the queue is empty.
    `BDQ_ASSERT_NOW(a_underflow_empty, i_clk, i_rst_n, o_strobe && o_status == ST_UNDERFLOW, o_fill_level == '0, "underflow while not empty")

endmodule
